/* design/vsg_pkg.sv */
// vsg_pkg: shared constants, types and command struct for the volume sobel gradient block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package vsg_pkg;

    localparam int MAX_DIM    = 64;
    localparam int VOXEL_BITS = 16;

    localparam int DIM_BITS   = $clog2(MAX_DIM);
    localparam int COORD_BITS = DIM_BITS + 1;
    localparam int ADDR_BITS  = 3 * DIM_BITS;
    localparam int SIZE_BITS  = 7;
    localparam int GRAD_BITS  = 21;
    localparam int OFF_BITS   = 2;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;
    localparam int REG_IDX_BITS  = 2;

    // register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE_X = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE_Z = 2'd2;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(MAX_DIM);

    // neighbour offset codes: minus one, centre, plus one
    localparam logic [OFF_BITS-1:0] OFF_NEG = 2'd0;
    localparam logic [OFF_BITS-1:0] OFF_MID = 2'd1;
    localparam logic [OFF_BITS-1:0] OFF_POS = 2'd2;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAST = 4'b0100,
        S_HOLD = 4'b1000
    } vsg_state_t;

    typedef struct packed {
        logic                load_we;
        logic                start;
        logic                rd_en;
        logic [OFF_BITS-1:0] off_x;
        logic [OFF_BITS-1:0] off_y;
        logic [OFF_BITS-1:0] off_z;
        logic                publish;
    } vsg_cmd_t;

endpackage

`default_nettype wire

/* design/vsg_regs.sv */
// vsg_regs: apb-style register file holding the three configured volume sizes
// depends on vsg_pkg
`timescale 1ns / 1ps
`default_nettype none

module vsg_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [vsg_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [vsg_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic      [vsg_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                     pready,
    output logic      [vsg_pkg::SIZE_BITS-1:0]       size_x,
    output logic      [vsg_pkg::SIZE_BITS-1:0]       size_y,
    output logic      [vsg_pkg::SIZE_BITS-1:0]       size_z
);

    logic [vsg_pkg::SIZE_BITS-1:0]    size_x_reg;
    logic [vsg_pkg::SIZE_BITS-1:0]    size_y_reg;
    logic [vsg_pkg::SIZE_BITS-1:0]    size_z_reg;
    logic [vsg_pkg::REG_IDX_BITS-1:0] reg_idx;
    logic                             wr_en;

    assign reg_idx = paddr[vsg_pkg::APB_ADDR_BITS-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= vsg_pkg::SIZE_RESET;
            size_y_reg <= vsg_pkg::SIZE_RESET;
            size_z_reg <= vsg_pkg::SIZE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                vsg_pkg::REG_SIZE_X: size_x_reg <= pwdata[vsg_pkg::SIZE_BITS-1:0];
                vsg_pkg::REG_SIZE_Y: size_y_reg <= pwdata[vsg_pkg::SIZE_BITS-1:0];
                vsg_pkg::REG_SIZE_Z: size_z_reg <= pwdata[vsg_pkg::SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            vsg_pkg::REG_SIZE_X: prdata = vsg_pkg::APB_DATA_BITS'(size_x_reg);
            vsg_pkg::REG_SIZE_Y: prdata = vsg_pkg::APB_DATA_BITS'(size_y_reg);
            vsg_pkg::REG_SIZE_Z: prdata = vsg_pkg::APB_DATA_BITS'(size_z_reg);
            default:             prdata = '0;
        endcase
    end

    assign size_x = size_x_reg;
    assign size_y = size_y_reg;
    assign size_z = size_z_reg;

endmodule

`default_nettype wire

/* design/vsg_ctrl.sv */
// vsg_ctrl: request handshake, neighbour scan sequencer and result valid flag
// depends on vsg_pkg
`timescale 1ns / 1ps
`default_nettype none

module vsg_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              mode,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output vsg_pkg::vsg_cmd_t      cmd
);

    vsg_pkg::vsg_state_t state_reg, state_next;

    logic [vsg_pkg::OFF_BITS-1:0] off_x_reg, off_x_next;
    logic [vsg_pkg::OFF_BITS-1:0] off_y_reg, off_y_next;
    logic [vsg_pkg::OFF_BITS-1:0] off_z_reg, off_z_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         accept;
    logic                         slot_free;

    assign in_ready  = (state_reg == vsg_pkg::S_IDLE);
    assign accept    = in_valid & in_ready;
    assign slot_free = ~out_valid_reg | out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        off_x_next     = off_x_reg;
        off_y_next     = off_y_reg;
        off_z_next     = off_z_reg;
        out_valid_next = out_valid_reg & ~out_ready;

        cmd         = '0;
        cmd.off_x   = off_x_reg;
        cmd.off_y   = off_y_reg;
        cmd.off_z   = off_z_reg;

        case (state_reg)
            vsg_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == vsg_pkg::MODE_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        off_x_next = vsg_pkg::OFF_NEG;
                        off_y_next = vsg_pkg::OFF_NEG;
                        off_z_next = vsg_pkg::OFF_NEG;
                        state_next = vsg_pkg::S_SCAN;
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            vsg_pkg::S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                // x fastest, then y, then z
                if (off_x_reg != vsg_pkg::OFF_POS)
                begin
                    off_x_next = off_x_reg + 1'b1;
                end
                else
                begin
                    off_x_next = vsg_pkg::OFF_NEG;
                    if (off_y_reg != vsg_pkg::OFF_POS)
                    begin
                        off_y_next = off_y_reg + 1'b1;
                    end
                    else
                    begin
                        off_y_next = vsg_pkg::OFF_NEG;
                        if (off_z_reg != vsg_pkg::OFF_POS)
                        begin
                            off_z_next = off_z_reg + 1'b1;
                        end
                        else
                        begin
                            state_next = vsg_pkg::S_LAST;
                        end
                    end
                end
            end
            vsg_pkg::S_LAST:
            begin
                state_next = vsg_pkg::S_HOLD;
            end
            vsg_pkg::S_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = vsg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = vsg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vsg_pkg::S_IDLE;
            off_x_reg     <= vsg_pkg::OFF_NEG;
            off_y_reg     <= vsg_pkg::OFF_NEG;
            off_z_reg     <= vsg_pkg::OFF_NEG;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            off_x_reg     <= off_x_next;
            off_y_reg     <= off_y_next;
            off_z_reg     <= off_z_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* design/vsg_datapath.sv */
// vsg_datapath: voxel memory, neighbour address generation, three accumulators, result registers
// depends on vsg_pkg
`timescale 1ns / 1ps
`default_nettype none

module vsg_datapath (
    input  wire logic                                    clk,
    input  wire vsg_pkg::vsg_cmd_t                       cmd,
    input  wire logic        [vsg_pkg::DIM_BITS-1:0]     pos_x,
    input  wire logic        [vsg_pkg::DIM_BITS-1:0]     pos_y,
    input  wire logic        [vsg_pkg::DIM_BITS-1:0]     pos_z,
    input  wire logic        [vsg_pkg::VOXEL_BITS-1:0]   voxel_value,
    input  wire logic        [vsg_pkg::SIZE_BITS-1:0]    size_x,
    input  wire logic        [vsg_pkg::SIZE_BITS-1:0]    size_y,
    input  wire logic        [vsg_pkg::SIZE_BITS-1:0]    size_z,
    output logic signed      [vsg_pkg::GRAD_BITS-1:0]    grad_x,
    output logic signed      [vsg_pkg::GRAD_BITS-1:0]    grad_y,
    output logic signed      [vsg_pkg::GRAD_BITS-1:0]    grad_z
);

    localparam int CB = vsg_pkg::COORD_BITS;
    localparam int GB = vsg_pkg::GRAD_BITS;
    localparam int OB = vsg_pkg::OFF_BITS;

    logic [vsg_pkg::VOXEL_BITS-1:0] mem [vsg_pkg::MAX_DIM**3];

    logic [vsg_pkg::DIM_BITS-1:0]   pos_x_reg, pos_y_reg, pos_z_reg;
    logic [vsg_pkg::VOXEL_BITS-1:0] rd_data_reg;
    logic                           tap_valid_reg;
    logic                           tap_oob_reg;
    logic [OB-1:0]                  tap_x_reg, tap_y_reg, tap_z_reg;
    logic signed [GB-1:0]           acc_x_reg, acc_y_reg, acc_z_reg;
    logic signed [GB-1:0]           grad_x_reg, grad_y_reg, grad_z_reg;

    logic [CB-1:0]                  ext_x, ext_y, ext_z;
    logic [CB-1:0]                  lim_x, lim_y, lim_z;
    logic                           oob;
    logic [vsg_pkg::ADDR_BITS-1:0]  rd_addr;
    logic [vsg_pkg::ADDR_BITS-1:0]  wr_addr;
    logic [vsg_pkg::VOXEL_BITS-1:0] tap_val;

    // clamp configured size to the stored cube
    function automatic logic [CB-1:0] clamp_size(input logic [vsg_pkg::SIZE_BITS-1:0] s);
        if (s > vsg_pkg::SIZE_BITS'(vsg_pkg::MAX_DIM))
        begin
            return CB'(vsg_pkg::MAX_DIM);
        end
        return CB'(s);
    endfunction

    // signed contribution of one tap: sign from the gradient axis, 1/2/4 weight across the others
    function automatic logic signed [GB-1:0] tap_term(
        input logic [vsg_pkg::VOXEL_BITS-1:0] v,
        input logic [OB-1:0]                  along,
        input logic [OB-1:0]                  across_a,
        input logic [OB-1:0]                  across_b
    );
        logic [GB-1:0] mag;
        mag = GB'(v);
        if (across_a == vsg_pkg::OFF_MID)
        begin
            mag = mag << 1;
        end
        if (across_b == vsg_pkg::OFF_MID)
        begin
            mag = mag << 1;
        end
        case (along)
            vsg_pkg::OFF_POS: return $signed(mag);
            vsg_pkg::OFF_NEG: return -$signed(mag);
            default:          return '0;
        endcase
    endfunction

    // neighbour coordinate plus one, so that zero means below the volume
    assign ext_x = CB'(pos_x_reg) + CB'(cmd.off_x);
    assign ext_y = CB'(pos_y_reg) + CB'(cmd.off_y);
    assign ext_z = CB'(pos_z_reg) + CB'(cmd.off_z);

    assign lim_x = clamp_size(size_x);
    assign lim_y = clamp_size(size_y);
    assign lim_z = clamp_size(size_z);

    assign oob = (ext_x == '0) || (ext_x > lim_x) ||
                 (ext_y == '0) || (ext_y > lim_y) ||
                 (ext_z == '0) || (ext_z > lim_z);

    logic [CB-1:0] crd_x, crd_y, crd_z;
    assign crd_x = ext_x - 1'b1;
    assign crd_y = ext_y - 1'b1;
    assign crd_z = ext_z - 1'b1;

    assign rd_addr = {crd_z[vsg_pkg::DIM_BITS-1:0], crd_y[vsg_pkg::DIM_BITS-1:0],
                      crd_x[vsg_pkg::DIM_BITS-1:0]};
    assign wr_addr = {pos_z, pos_y, pos_x};

    // single port voxel memory
    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            mem[wr_addr] <= voxel_value;
        end
        else if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            pos_z_reg <= pos_z;
        end
        tap_valid_reg <= cmd.rd_en;
        tap_oob_reg   <= oob;
        tap_x_reg     <= cmd.off_x;
        tap_y_reg     <= cmd.off_y;
        tap_z_reg     <= cmd.off_z;
    end

    assign tap_val = tap_oob_reg ? vsg_pkg::VOXEL_BITS'(1) : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
        end
        else if (tap_valid_reg)
        begin
            acc_x_reg <= acc_x_reg + tap_term(tap_val, tap_x_reg, tap_y_reg, tap_z_reg);
            acc_y_reg <= acc_y_reg + tap_term(tap_val, tap_y_reg, tap_x_reg, tap_z_reg);
            acc_z_reg <= acc_z_reg + tap_term(tap_val, tap_z_reg, tap_x_reg, tap_y_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            grad_x_reg <= acc_x_reg;
            grad_y_reg <= acc_y_reg;
            grad_z_reg <= acc_z_reg;
        end
    end

    assign grad_x = grad_x_reg;
    assign grad_y = grad_y_reg;
    assign grad_z = grad_z_reg;

endmodule

`default_nettype wire

/* design/volume_sobel_gradient.sv */
// volume_sobel_gradient: top level of the 3x3x3 sobel gradient engine over a stored voxel cube
// depends on vsg_pkg, vsg_regs, vsg_ctrl, vsg_datapath
//
//  channel   direction  handshake                     payload
//  in        request    in_valid / in_ready           mode, pos_x, pos_y, pos_z, voxel_value
//  out       result     out_valid / out_ready         grad_x, grad_y, grad_z
//  config    apb write  psel, penable, pwrite, pready paddr, pwdata, prdata
//
//  load: voxel written at the accept edge; the engine stays idle, so the next request can be taken in the next cycle
//  query: 27 neighbour reads, one per cycle on the single memory port, then a state for
//  the last accumulate and one to publish; the result is offered by the publish, and
//  the next request can be taken once the engine is back in idle
//  a waiting result holds in the output register; only a query's publish stalls on it
//  reset clears control state and the sizes (64 each), not the voxel memory
`timescale 1ns / 1ps
`default_nettype none

module volume_sobel_gradient (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic        [vsg_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic        [vsg_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic             [vsg_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                       pready,
    // request in
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  mode,
    input  wire logic        [vsg_pkg::DIM_BITS-1:0]   pos_x,
    input  wire logic        [vsg_pkg::DIM_BITS-1:0]   pos_y,
    input  wire logic        [vsg_pkg::DIM_BITS-1:0]   pos_z,
    input  wire logic        [vsg_pkg::VOXEL_BITS-1:0] voxel_value,
    // result out
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed      [vsg_pkg::GRAD_BITS-1:0]  grad_x,
    output logic signed      [vsg_pkg::GRAD_BITS-1:0]  grad_y,
    output logic signed      [vsg_pkg::GRAD_BITS-1:0]  grad_z
);

    // configured sizes, held in the register block
    logic [vsg_pkg::SIZE_BITS-1:0] size_x;
    logic [vsg_pkg::SIZE_BITS-1:0] size_y;
    logic [vsg_pkg::SIZE_BITS-1:0] size_z;

    // command bundle from the sequencer to the datapath
    vsg_pkg::vsg_cmd_t cmd;

    vsg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .size_x  (size_x),
        .size_y  (size_y),
        .size_z  (size_z)
    );

    // sequencer: takes requests, walks the 27 neighbours, owns the result valid flag
    vsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // memory, out-of-volume test, weighted accumulation and result registers
    vsg_datapath u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .voxel_value (voxel_value),
        .size_x      (size_x),
        .size_y      (size_y),
        .size_z      (size_z),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .grad_z      (grad_z)
    );

endmodule

`default_nettype wire

/* design/vsg_checker.sv */
// vsg_checker: port-level assertions for the volume sobel gradient block, bound to the top level
// depends on vsg_pkg and volume_sobel_gradient
`timescale 1ns / 1ps
`default_nettype none

module vsg_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_ready,
    input  wire logic                                 mode,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic signed [vsg_pkg::GRAD_BITS-1:0] grad_x,
    input  wire logic signed [vsg_pkg::GRAD_BITS-1:0] grad_y,
    input  wire logic signed [vsg_pkg::GRAD_BITS-1:0] grad_z,
    input  wire logic                                 pready
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(grad_x) && $stable(grad_y) && $stable(grad_z))
        else $error("result payload changed while stalled");

    // a query occupies the engine, so no request is taken in the following cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode |=> !in_ready)
        else $error("request taken directly after a query");

    // a query cannot produce its result in the next cycle
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode |=> !$rose(out_valid))
        else $error("result appeared too early after a query");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("config port not ready");

endmodule

bind volume_sobel_gradient vsg_checker u_vsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .grad_x    (grad_x),
    .grad_y    (grad_y),
    .grad_z    (grad_z),
    .pready    (pready)
);

`default_nettype wire
